// File: design/min_conflict_channel_assign_assert.svh
// Assertion macros for the checker file of this block.
`ifndef MIN_CONFLICT_CHANNEL_ASSIGN_ASSERT_SVH
`define MIN_CONFLICT_CHANNEL_ASSIGN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCCA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mcca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcca_pkg;

    localparam int MCCA_MAX_VERTICES = 64;
    localparam int MCCA_MAX_CLASSES  = 16;

    // The channel field is four bits wide, so no more classes than this.
    localparam int CLASS_LIMIT   = 16;
    localparam int CLASS_W       = 4;
    localparam int CHARGE_W      = 16;
    localparam int ADJ_W         = 64;
    localparam int VERTEX_W      = 6;
    localparam int SUM_W         = 22;
    localparam int NUM_CLASSES_W = 5;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_CLASSES   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTED_MODE = 4'd1;

    localparam logic [NUM_CLASSES_W-1:0] NUM_CLASSES_RESET = 5'd16;

    typedef struct packed {
        logic [CLASS_W-1:0]  cls;
        logic [CHARGE_W-1:0] charge;
    } mcca_entry_t;

endpackage

`default_nettype wire

// File: design/mcca_vertex_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mcca_vertex_store
    import mcca_pkg::*;
#(
    parameter int DEPTH = MCCA_MAX_VERTICES,
    parameter int AW    = $clog2(MCCA_MAX_VERTICES)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire mcca_entry_t   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output mcca_entry_t        rd_data
);

    mcca_entry_t mem [DEPTH];
    mcca_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/min_conflict_channel_assign.sv
`timescale 1ns / 1ps
`default_nettype none

// Greedy minimum-conflict channel assignment.
// Each input transfer carries one vertex: its adjacency bits to earlier
// vertices, its unsigned Q8.8 charge and a flag that starts a new graph.
// Each vertex produces exactly one result transfer with its index, the chosen
// channel, the winning conflict sum and an overflow flag for a full store.
// The configuration channel is always ready and sets the number of classes
// and whether charges are summed or neighbours counted.
// For a vertex with index n above zero, the scan reads one stored vertex a
// cycle from the single read port of the vertex store, waits for the last
// read to land and then starts the selection, and one comparator then walks
// the k accumulators of the classes in use. The first vertex of a graph has
// no stored vertices to read; an overflowed vertex goes straight to its
// result. Only one vertex is in work at a time; s_ready is high when the
// block is idle, so the next vertex is accepted only once the previous result
// is registered. The result sits in an output register, so a new vertex is
// accepted while the previous result still waits; if the receiver still
// stalls when the next vertex is done, that vertex waits until the output
// register is free.
// Reset empties the graph, sets 16 classes and weighted mode, and drops
// m_valid. The vertex store itself is not cleared.
module min_conflict_channel_assign
    import mcca_pkg::*;
#(
    parameter int MAX_VERTICES = MCCA_MAX_VERTICES,
    parameter int MAX_CLASSES  = MCCA_MAX_CLASSES
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [ADJ_W-1:0]       s_adjacency,
    input  wire logic [CHARGE_W-1:0]    s_charge,
    input  wire logic                   s_first_vertex,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [VERTEX_W-1:0]         m_vertex_index,
    output logic [CLASS_W-1:0]          m_channel,
    output logic [SUM_W-1:0]            m_conflict_sum,
    output logic                        m_overflow,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int KMAX = (MAX_CLASSES < CLASS_LIMIT) ? MAX_CLASSES : CLASS_LIMIT;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SELECT = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [NUM_CLASSES_W-1:0] num_classes_reg;
    logic                     weighted_mode_reg;

    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           scan_cnt_reg, scan_cnt_next;
    logic                    ovf_reg, ovf_next;
    logic [MAX_VERTICES-1:0] adj_reg, adj_next;
    logic [CHARGE_W-1:0]     charge_reg, charge_next;
    logic                    pend_reg, pend_next;
    logic                    hit_reg, hit_next;

    logic [SUM_W-1:0]         acc_reg [CLASS_LIMIT];
    logic [SUM_W-1:0]         acc_next [CLASS_LIMIT];
    logic [NUM_CLASSES_W-1:0] sel_cnt_reg, sel_cnt_next;
    logic [CLASS_W-1:0]       best_reg, best_next;
    logic [SUM_W-1:0]         best_sum_reg, best_sum_next;

    logic                m_valid_reg, m_valid_next;
    logic [VERTEX_W-1:0] out_index_reg, out_index_next;
    logic [CLASS_W-1:0]  out_channel_reg, out_channel_next;
    logic [SUM_W-1:0]    out_sum_reg, out_sum_next;
    logic                out_ovf_reg, out_ovf_next;

    logic [NUM_CLASSES_W-1:0] k_active;
    logic [CW-1:0]            count_eff;
    logic [SUM_W-1:0]         inc;
    logic                     rd_en, wr_en;
    mcca_entry_t              rd_data, wr_data;

    mcca_vertex_store #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Zero classes act as one; larger values saturate to what the hardware holds.
    always_comb begin
        k_active = num_classes_reg;
        if (num_classes_reg == '0) begin
            k_active = NUM_CLASSES_W'(1);
        end else if (num_classes_reg > NUM_CLASSES_W'(KMAX)) begin
            k_active = NUM_CLASSES_W'(KMAX);
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign count_eff = s_first_vertex ? '0 : count_reg;
    assign inc       = weighted_mode_reg ? SUM_W'(rd_data.charge) : SUM_W'(1);
    assign rd_en     = (state_reg == ST_SCAN) && (scan_cnt_reg < idx_reg);
    assign wr_en     = (state_reg == ST_DONE) && (!m_valid_reg || m_ready) && !ovf_reg;
    assign wr_data   = '{cls: best_reg, charge: charge_reg};

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        scan_cnt_next    = scan_cnt_reg;
        ovf_next         = ovf_reg;
        adj_next         = adj_reg;
        charge_next      = charge_reg;
        pend_next        = 1'b0;
        hit_next         = hit_reg;
        acc_next         = acc_reg;
        sel_cnt_next     = sel_cnt_reg;
        best_next        = best_reg;
        best_sum_next    = best_sum_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_index_next   = out_index_reg;
        out_channel_next = out_channel_reg;
        out_sum_next     = out_sum_reg;
        out_ovf_next     = out_ovf_reg;

        // The read issued last cycle lands now; add it to its class.
        if (pend_reg && hit_reg) begin
            acc_next[rd_data.cls] = acc_reg[rd_data.cls] + inc;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    count_next    = count_eff;
                    idx_next      = count_eff;
                    scan_cnt_next = '0;
                    adj_next      = s_adjacency[MAX_VERTICES-1:0];
                    charge_next   = s_charge;
                    for (int c = 0; c < CLASS_LIMIT; c++) begin
                        acc_next[c] = '0;
                    end
                    if (count_eff == CW'(MAX_VERTICES)) begin
                        ovf_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        ovf_next   = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg < idx_reg) begin
                    pend_next     = 1'b1;
                    hit_next      = adj_reg[scan_cnt_reg[AW-1:0]];
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end else if (!pend_reg) begin
                    best_next     = '0;
                    best_sum_next = acc_reg[0];
                    sel_cnt_next  = NUM_CLASSES_W'(1);
                    state_next    = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (sel_cnt_reg < k_active) begin
                    if (acc_reg[sel_cnt_reg[CLASS_W-1:0]] < best_sum_reg) begin
                        best_sum_next = acc_reg[sel_cnt_reg[CLASS_W-1:0]];
                        best_next     = sel_cnt_reg[CLASS_W-1:0];
                    end
                    sel_cnt_next = sel_cnt_reg + NUM_CLASSES_W'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_ovf_next = ovf_reg;
                    if (ovf_reg) begin
                        out_index_next   = '0;
                        out_channel_next = '0;
                        out_sum_next     = '0;
                    end else begin
                        out_index_next   = VERTEX_W'(idx_reg[AW-1:0]);
                        out_channel_next = best_reg;
                        out_sum_next     = best_sum_reg;
                        count_next       = idx_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            pend_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
            num_classes_reg   <= NUM_CLASSES_RESET;
            weighted_mode_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_NUM_CLASSES:   num_classes_reg   <= cfg_data[NUM_CLASSES_W-1:0];
                    REG_WEIGHTED_MODE: weighted_mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        scan_cnt_reg    <= scan_cnt_next;
        ovf_reg         <= ovf_next;
        adj_reg         <= adj_next;
        charge_reg      <= charge_next;
        hit_reg         <= hit_next;
        acc_reg         <= acc_next;
        sel_cnt_reg     <= sel_cnt_next;
        best_reg        <= best_next;
        best_sum_reg    <= best_sum_next;
        out_index_reg   <= out_index_next;
        out_channel_reg <= out_channel_next;
        out_sum_reg     <= out_sum_next;
        out_ovf_reg     <= out_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_vertex_index = out_index_reg;
    assign m_channel      = out_channel_reg;
    assign m_conflict_sum = out_sum_reg;
    assign m_overflow     = out_ovf_reg;

endmodule

`default_nettype wire

// File: design/mcca_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "min_conflict_channel_assign_assert.svh"

module mcca_checker
    import mcca_pkg::*;
#(
    parameter int MAX_VERTICES = MCCA_MAX_VERTICES
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [VERTEX_W-1:0] m_vertex_index,
    input wire logic [CLASS_W-1:0]  m_channel,
    input wire logic [SUM_W-1:0]    m_conflict_sum,
    input wire logic                m_overflow
);

    localparam int FIELDS_W = VERTEX_W + CLASS_W + SUM_W + 1;

    logic                s_fire;
    logic                m_stall;
    logic                ovf_out;
    logic                good_out;
    logic                fields_zero;
    logic                index_ok;
    logic [FIELDS_W-1:0] m_fields;

    assign s_fire      = s_valid && s_ready;
    assign m_stall     = m_valid && !m_ready;
    assign ovf_out     = m_valid && m_overflow;
    assign good_out    = m_valid && !m_overflow;
    assign fields_zero = (m_vertex_index == '0) && (m_channel == '0) && (m_conflict_sum == '0);
    assign index_ok    = 32'(m_vertex_index) < 32'(MAX_VERTICES);
    assign m_fields    = {m_vertex_index, m_channel, m_conflict_sum, m_overflow};

    // Only one vertex is in work, so an accepted transfer closes the input side.
    `MCCA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_fire, !s_ready, "ready after a transfer")

    `MCCA_ASSERT_SAME(a_overflow_zero, aclk, aresetn, ovf_out, fields_zero, "overflow fields set")

    `MCCA_ASSERT_SAME(a_index_in_range, aclk, aresetn, good_out, index_ok, "index beyond capacity")

    `MCCA_ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_stall, m_valid, "stalled result dropped")

    `MCCA_ASSERT_NEXT(a_fields_hold, aclk, aresetn, m_stall, $stable(m_fields), "result changed")

endmodule

bind min_conflict_channel_assign mcca_checker #(.MAX_VERTICES(MAX_VERTICES)) u_mcca_checker (.*);

`default_nettype wire

// File: tb/channel_assign_checker.sv
`timescale 1ns / 1ps

module channel_assign_checker
    import mcca_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire logic [ADJ_W-1:0]       s_adjacency,
    input  wire logic [CHARGE_W-1:0]    s_charge,
    input  wire logic                   s_first_vertex,

    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire logic [VERTEX_W-1:0]    m_vertex_index,
    input  wire logic [CLASS_W-1:0]     m_channel,
    input  wire logic [SUM_W-1:0]       m_conflict_sum,
    input  wire logic                   m_overflow,

    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    output int unsigned                 error_count,
    output int unsigned                 pending_results
);

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_index;
        logic [CLASS_W-1:0]  channel;
        logic [SUM_W-1:0]    conflict_sum;
        logic                overflow;
    } channel_result_t;

    channel_result_t expected_results[$];

    logic [CLASS_W-1:0]       placed_class  [MCCA_MAX_VERTICES];
    logic [CHARGE_W-1:0]      placed_charge [MCCA_MAX_VERTICES];
    int unsigned              placed_count;
    logic [NUM_CLASSES_W-1:0] class_setting;
    logic                     weighted_setting;
    int unsigned              mismatches;

    // Greedy choice for one vertex; updates the local copy of the store.
    function automatic channel_result_t assign_channel(input logic [ADJ_W-1:0] adj,
                                                       input logic [CHARGE_W-1:0] chg,
                                                       input logic first);
        channel_result_t  res;
        logic [SUM_W-1:0] class_sum [CLASS_LIMIT];
        int unsigned      in_use;
        int unsigned      best;
        int unsigned      u;
        int unsigned      c;
        res = '0;
        if (first)
            placed_count = 0;
        if (placed_count >= MCCA_MAX_VERTICES) begin
            res.overflow = 1'b1;
            return res;
        end
        in_use = class_setting;
        if (in_use < 1)
            in_use = 1;
        if (in_use > MCCA_MAX_CLASSES)
            in_use = MCCA_MAX_CLASSES;
        if (in_use > CLASS_LIMIT)
            in_use = CLASS_LIMIT;
        for (c = 0; c < CLASS_LIMIT; c++)
            class_sum[c] = '0;
        // Adjacency bits at or above this vertex's own index never enter the scan.
        for (u = 0; u < placed_count; u++) begin
            if (adj[u]) begin
                if (weighted_setting)
                    class_sum[placed_class[u]] += SUM_W'(placed_charge[u]);
                else
                    class_sum[placed_class[u]] += SUM_W'(1);
            end
        end
        best = 0;
        for (c = 1; c < in_use; c++) begin
            if (class_sum[c] < class_sum[best])
                best = c;
        end
        placed_class[placed_count]  = CLASS_W'(best);
        placed_charge[placed_count] = chg;
        res.vertex_index = VERTEX_W'(placed_count);
        res.channel      = CLASS_W'(best);
        res.conflict_sum = class_sum[best];
        placed_count++;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        channel_result_t want;
        if (!aresetn) begin
            placed_count     = 0;
            class_setting    = NUM_CLASSES_RESET;
            weighted_setting = 1'b1;
            expected_results.delete();
        end else begin
            // Results are matched before this edge's vertex is predicted, as a
            // result can never belong to a vertex accepted at the same edge.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: index %0d channel %0d sum %0d overflow %0b",
                             $time, m_vertex_index, m_channel, m_conflict_sum, m_overflow);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("vertex_index", SUM_W'(want.vertex_index), SUM_W'(m_vertex_index));
                    check_field("channel", SUM_W'(want.channel), SUM_W'(m_channel));
                    check_field("conflict_sum", want.conflict_sum, m_conflict_sum);
                    check_field("overflow", SUM_W'(want.overflow), SUM_W'(m_overflow));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_CLASSES:   class_setting    = cfg_data[NUM_CLASSES_W-1:0];
                    REG_WEIGHTED_MODE: weighted_setting = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_results = {expected_results,
                                    assign_channel(s_adjacency, s_charge, s_first_vertex)};
        end
        pending_results <= expected_results.size();
        error_count     <= mismatches;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mcca_pkg::*;

    // No register lives at this index; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'hF;
    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned TAIL_CYCLES  = 100;
    localparam int unsigned RANDOM_ITEMS = 700;

    typedef enum int unsigned {
        DENSITY_SPARSE,
        DENSITY_LIGHT,
        DENSITY_HALF,
        DENSITY_DENSE
    } density_e;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic [ADJ_W-1:0]       s_adjacency    = '0;
    logic [CHARGE_W-1:0]    s_charge       = '0;
    logic                   s_first_vertex = 1'b0;
    logic                   m_ready        = 1'b0;
    logic                   cfg_valid      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = REG_NUM_CLASSES;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;

    wire logic              s_ready;
    wire logic              m_valid;
    wire logic [VERTEX_W-1:0] m_vertex_index;
    wire logic [CLASS_W-1:0]  m_channel;
    wire logic [SUM_W-1:0]    m_conflict_sum;
    wire logic              m_overflow;
    wire logic              cfg_ready;
    int unsigned            error_count;
    int unsigned            pending_results;

    // While set, neither side idles.
    bit          steady     = 1'b0;
    int unsigned items_sent = 0;
    int unsigned ready_hold = 0;

    always #2 aclk = ~aclk;

    min_conflict_channel_assign dut (.*);

    channel_assign_checker channel_check (.*);

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (steady || r < 8)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [ADJ_W-1:0] random_adjacency(input density_e density);
        logic [ADJ_W-1:0] a;
        logic [ADJ_W-1:0] b;
        logic [ADJ_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (density)
            DENSITY_SPARSE: return a & b & c;
            DENSITY_LIGHT:  return a & b;
            DENSITY_HALF:   return a;
            default:        return a | b;
        endcase
    endfunction

    function automatic logic [CHARGE_W-1:0] random_charge();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CHARGE_W'($urandom_range(0, 255));
            default: return CHARGE_W'($urandom);
        endcase
    endfunction

    // The receiver holds each ready level for a random number of cycles.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= steady || ($urandom_range(0, 3) != 0);
            ready_hold <= pick_gap();
        end
    end

    task automatic send_vertex(input logic [ADJ_W-1:0] adj, input logic [CHARGE_W-1:0] chg,
                               input logic first);
        int unsigned gap;
        gap = pick_gap();
        // Valid is only lowered when a gap follows, never within one step.
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_adjacency    <= adj;
        s_charge       <= chg;
        s_first_vertex <= first;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] classes, input logic [CFG_DATA_W-1:0] mode);
        drain();
        repeat (4) @(posedge aclk);
        write_reg(REG_NUM_CLASSES, classes);
        write_reg(REG_WEIGHTED_MODE, mode);
    endtask

    initial begin
        int unsigned random_target;
        int unsigned graph_no;
        int unsigned graph_len;
        int unsigned v;
        density_e    density;
        logic        first;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: sixteen classes, charges summed.
        send_vertex('1, 16'hFFFF, 1'b1);
        send_vertex(64'h1, 16'h0100, 1'b0);
        send_vertex(64'h3, 16'h8000, 1'b0);
        send_vertex(64'h7, 16'h0001, 1'b0);
        send_vertex('0, '0, 1'b0);
        send_vertex('1, 16'h1234, 1'b0);
        // Only bits at or above the vertex's own index are set here.
        send_vertex(64'hFFFF_FFFF_FFFF_FFC0, 16'hFFFF, 1'b0);
        // A new graph starts in the middle of the stream.
        send_vertex('1, 16'h00FF, 1'b1);
        send_vertex(64'h1, '0, 1'b0);

        // A class count of zero behaves as one; neighbours are counted.
        configure(8'h00, 8'h00);
        send_vertex('1, 16'hFFFF, 1'b1);
        send_vertex('1, 16'hFFFF, 1'b0);
        send_vertex('1, '0, 1'b0);

        // Upper data bits are dropped, and 31 classes saturate to sixteen.
        configure(8'hFF, 8'hFF);
        write_reg(REG_UNUSED, 8'hFF);
        send_vertex('1, 16'h4000, 1'b1);
        send_vertex(64'h1, 16'h0010, 1'b0);
        send_vertex(64'h3, 16'hFFFF, 1'b0);

        // One class and full charges fill the store, reach the largest sum and
        // run past the capacity; a new graph then starts from a full store.
        configure(8'h01, 8'h01);
        for (v = 0; v < MCCA_MAX_VERTICES + 3; v++)
            send_vertex('1, 16'hFFFF, v == 0);
        send_vertex('1, 16'hFFFF, 1'b1);

        configure(8'h10, 8'hFE);
        random_target = items_sent + RANDOM_ITEMS;
        graph_no = 0;
        while (items_sent < random_target) begin
            if (graph_no % 6 == 5) begin
                if ($urandom_range(0, 3) == 0)
                    configure({3'($urandom), 5'($urandom)}, CFG_DATA_W'($urandom));
                else
                    configure({3'($urandom), 5'($urandom_range(1, 16))},
                              CFG_DATA_W'($urandom));
            end
            steady  = ($urandom_range(0, 5) == 0);
            density = density_e'($urandom_range(0, 3));
            graph_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 20);
            for (v = 0; v < graph_len; v++) begin
                first = (v == 0);
                // Now and then a graph is broken up or runs on into the last one.
                if ($urandom_range(0, 24) == 0)
                    first = ~first;
                send_vertex(random_adjacency(density), random_charge(), first);
            end
            graph_no++;
        end

        steady = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
